// File: src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define POBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define POBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: src/pobc_pkg.sv
package pobc_pkg;

    localparam int NUM_PORTS_DEF = 8;
    localparam int NUM_PRIORITIES_DEF = 4;
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] PORTS_IN_USE_RST = 4'd5;
    localparam logic [15:0] FOREVER_CYCLES = 16'hFFFF;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_INSTALL   = 3'd3;
    localparam logic [2:0] OP_REMOVE    = 3'd4;
    localparam logic [2:0] OP_SET_LEVEL = 3'd5;
    localparam logic [2:0] OP_QUERY     = 3'd6;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  port;
        logic [1:0]  priority_req;
        logic [15:0] cycles;
        logic [7:0]  high_ticks;
        logic [7:0]  low_ticks;
        logic        notify;
        logic        drive_level;
    } t_item;

    typedef struct packed {
        logic [2:0] out_port;
        logic       out_level;
        logic       driving;
        logic       run_done;
        logic [1:0] done_priority;
        logic       rejected;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [15:0] remaining;
        logic [7:0]  high_count;
        logic [7:0]  low_count;
        logic [7:0]  high_reload;
        logic [7:0]  low_reload;
        logic        notify_en;
    } t_slot;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_DISP  = 3'd1;
    localparam t_step STEP_TSEL  = 3'd2;
    localparam t_step STEP_TUPD  = 3'd3;
    localparam t_step STEP_CEXEC = 3'd4;

    typedef enum logic [2:0] {
        COND_NEXT    = 3'd0,
        COND_WAIT_IN = 3'd1,
        COND_CMD     = 3'd2,
        COND_PDONE   = 3'd3,
        COND_OUT_GO  = 3'd4
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  rd_slot;
        logic  upd_tick;
        logic  exec_cmd;
        t_cond cond;
        t_step target;
    } t_cw;

    typedef struct packed {
        logic in_valid;
        logic is_cmd;
        logic ports_done;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        logic accept;
        logic rd_slot;
        logic upd_tick;
        logic exec_cmd;
    } t_ctl;

endpackage

// File: src/pobc_item_if.sv
interface pobc_item_if;
    logic                 valid;
    logic                 ready;
    pobc_pkg::t_item      data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/pobc_result_if.sv
interface pobc_result_if;
    logic                 valid;
    logic                 ready;
    pobc_pkg::t_result    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/pobc_cfg_if.sv
interface pobc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pobc_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/pobc_ram.sv
module pobc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/pobc_seq.sv
module pobc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pobc_pkg::t_flags  i_flags,
    output pobc_pkg::t_ctl    o_ctl
);
    import pobc_pkg::*;

    t_step r_pc;
    t_step n_pc;
    t_cw   cw;

    function automatic t_cw f_ucode(input t_step s);
        t_cw w;
        w = '0;
        case (s)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.cond   = COND_WAIT_IN;
                w.target = STEP_IDLE;
            end
            STEP_DISP: begin
                w.cond   = COND_CMD;
                w.target = STEP_CEXEC;
            end
            STEP_TSEL: begin
                w.rd_slot = 1'b1;
                w.cond    = COND_PDONE;
                w.target  = STEP_IDLE;
            end
            STEP_TUPD: begin
                w.upd_tick = 1'b1;
                w.cond     = COND_OUT_GO;
                w.target   = STEP_TSEL;
            end
            STEP_CEXEC: begin
                w.exec_cmd = 1'b1;
                w.cond     = COND_OUT_GO;
                w.target   = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_OUT_GO;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign cw = f_ucode(r_pc);

    always_comb begin
        case (cw.cond)
            COND_NEXT:    n_pc = t_step'(r_pc + 3'd1);
            COND_WAIT_IN: n_pc = i_flags.in_valid ? t_step'(r_pc + 3'd1) : cw.target;
            COND_CMD:     n_pc = i_flags.is_cmd ? cw.target : t_step'(r_pc + 3'd1);
            COND_PDONE:   n_pc = i_flags.ports_done ? cw.target : t_step'(r_pc + 3'd1);
            COND_OUT_GO:  n_pc = i_flags.out_busy ? r_pc : cw.target;
            default:      n_pc = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.accept   = cw.accept;
    assign o_ctl.rd_slot  = cw.rd_slot & ~i_flags.ports_done;
    assign o_ctl.upd_tick = cw.upd_tick & ~i_flags.out_busy;
    assign o_ctl.exec_cmd = cw.exec_cmd & ~i_flags.out_busy;
endmodule

// File: src/prioritized_output_blink_controller.sv
// Blink driver for up to NUM_PORTS outputs, each with NUM_PRIORITIES blink slots held in
// a slot memory with one read and one write port; slot activity is kept in flip-flops, so no
// clearing pass is needed after reset. A small microcoded sequencer runs each beat: a tick
// steps through accept and dispatch, then one memory read and one update and result per
// serviced port, and a last read step that finds every port done; every command steps
// through accept, dispatch and execute and gives one result. A full result register lets
// the next beat start while a result still waits; a stalled result sink holds the
// sequencer in its update or execute step.
module prioritized_output_blink_controller #(
    parameter int NUM_PORTS      = pobc_pkg::NUM_PORTS_DEF,
    parameter int NUM_PRIORITIES = pobc_pkg::NUM_PRIORITIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pobc_item_if.sink     i_item,
    pobc_result_if.source o_result,
    pobc_cfg_if.sink      i_cfg
);
    import pobc_pkg::*;

    localparam int PORT_W = NUM_PORTS > 1 ? $clog2(NUM_PORTS) : 1;
    localparam int PRI_W  = NUM_PRIORITIES > 1 ? $clog2(NUM_PRIORITIES) : 1;
    localparam int SLOTS  = NUM_PORTS * NUM_PRIORITIES;
    localparam int ADDR_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_PORTS + 1);

    t_ctl   ctl;
    t_flags flags;

    logic [CFG_W-1:0]          r_ports_in_use;
    t_item                     r_item;
    logic [CNT_W-1:0]          r_cnt;
    logic [NUM_PORTS-1:0]      r_level;
    logic [NUM_PORTS-1:0]      r_drive;
    logic [NUM_PRIORITIES-1:0] r_act [NUM_PORTS];
    logic                      r_any;
    logic [PRI_W-1:0]          r_sel_pri;
    logic [ADDR_W-1:0]         r_slot_addr;
    t_result                   r_out;
    logic                      r_out_valid;

    logic [5:0]        lim;
    logic [CNT_W-1:0]  n_ports;
    logic [PORT_W-1:0] cnt_idx;
    logic [5:0]        cnt6;
    logic              sel_any;
    logic [PRI_W-1:0]  sel_pri;
    logic [ADDR_W-1:0] tick_addr;

    t_slot             cur;
    t_slot             tick_nxt;
    logic              tick_lvl;
    logic              tick_done;
    logic              tick_end;
    t_result           tick_res;

    logic [5:0]        port6;
    logic [PORT_W-1:0] cmd_port;
    logic [3:0]        pri4;
    logic [PRI_W-1:0]  cmd_pri;
    logic              port_ok;
    logic              pri_ok;
    logic [ADDR_W-1:0] cmd_addr;
    logic              cmd_rej;
    logic              cmd_we;
    logic              cmd_set;
    logic              cmd_clr;
    logic              cmd_lvl;
    t_slot             cmd_slot;
    t_result           cmd_res;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_slot             ram_wdata;
    logic              acc;

    assign acc = i_item.valid && i_item.ready;

    always_comb begin
        lim     = (6'(r_ports_in_use) > 6'(NUM_PORTS)) ? 6'(NUM_PORTS) : 6'(r_ports_in_use);
        n_ports = CNT_W'(lim);
        cnt_idx = r_cnt[PORT_W-1:0];
        cnt6    = 6'(r_cnt);
    end

    // First active slot of the port being serviced, priority 0 first.
    always_comb begin
        sel_any = 1'b0;
        sel_pri = '0;
        for (int j = NUM_PRIORITIES - 1; j >= 0; j--) begin
            if (r_act[cnt_idx][j]) begin
                sel_any = 1'b1;
                sel_pri = PRI_W'(j);
            end
        end
        tick_addr = ADDR_W'(ADDR_W'(cnt_idx) * ADDR_W'(NUM_PRIORITIES)) + ADDR_W'(sel_pri);
    end

    always_comb begin
        tick_nxt  = cur;
        tick_lvl  = r_level[cnt_idx];
        tick_done = 1'b0;
        tick_end  = 1'b0;
        if (cur.high_count != 8'd0) begin
            tick_nxt.high_count = cur.high_count - 8'd1;
            tick_lvl            = 1'b1;
        end else begin
            if (cur.low_count != 8'd0) begin
                tick_nxt.low_count = cur.low_count - 8'd1;
                tick_lvl           = 1'b0;
            end
            if (tick_nxt.low_count == 8'd0) begin
                if (cur.remaining != FOREVER_CYCLES) begin
                    tick_nxt.remaining = cur.remaining - 16'd1;
                end
                tick_end            = (tick_nxt.remaining == 16'd0);
                tick_done           = tick_end && cur.notify_en;
                tick_nxt.high_count = cur.high_reload;
                tick_nxt.low_count  = cur.low_reload;
            end
        end

        tick_res.out_port      = cnt6[2:0];
        tick_res.out_level     = r_any ? tick_lvl : r_level[cnt_idx];
        tick_res.driving       = r_any;
        tick_res.run_done      = r_any && tick_done;
        tick_res.done_priority = (r_any && tick_done) ? 2'(r_sel_pri) : 2'd0;
        tick_res.rejected      = 1'b0;
        tick_res.last          = ({1'b0, r_cnt} + (CNT_W + 1)'(1)) == {1'b0, n_ports};
    end

    always_comb begin
        port6    = 6'(r_item.port);
        cmd_port = port6[PORT_W-1:0];
        pri4     = 4'(r_item.priority_req);
        port_ok  = port6 < 6'(n_ports);
        pri_ok   = pri4 < 4'(NUM_PRIORITIES);
        cmd_pri  = pri4[PRI_W-1:0];
        cmd_rej  = 1'b0;
        cmd_we   = 1'b0;
        cmd_set  = 1'b0;
        cmd_clr  = 1'b0;
        cmd_lvl  = r_level[cmd_port];

        cmd_slot.remaining   = r_item.cycles;
        cmd_slot.high_count  = r_item.high_ticks;
        cmd_slot.low_count   = r_item.low_ticks;
        cmd_slot.high_reload = r_item.high_ticks;
        cmd_slot.low_reload  = r_item.low_ticks;
        cmd_slot.notify_en   = r_item.notify;

        case (r_item.operation)
            OP_START: begin
                if (!pri_ok || r_item.cycles == 16'd0 ||
                    (r_item.high_ticks == 8'd0 && r_item.low_ticks == 8'd0)) begin
                    cmd_rej = 1'b1;
                end else begin
                    cmd_we  = 1'b1;
                    cmd_set = 1'b1;
                end
            end
            OP_STOP: begin
                if (!pri_ok) begin
                    cmd_rej = 1'b1;
                end else begin
                    cmd_clr = 1'b1;
                    cmd_lvl = 1'b0;
                end
            end
            OP_INSTALL: begin
                cmd_pri             = PRI_W'(NUM_PRIORITIES - 1);
                cmd_slot.remaining  = FOREVER_CYCLES;
                cmd_slot.notify_en  = 1'b0;
                if (r_item.high_ticks == 8'd0 && r_item.low_ticks == 8'd0) begin
                    cmd_rej = 1'b1;
                end else begin
                    cmd_we  = 1'b1;
                    cmd_set = 1'b1;
                end
            end
            OP_REMOVE: begin
                cmd_pri = PRI_W'(NUM_PRIORITIES - 1);
                cmd_clr = 1'b1;
                cmd_lvl = 1'b0;
            end
            OP_SET_LEVEL: begin
                cmd_lvl = r_item.drive_level;
            end
            OP_QUERY: begin
                cmd_rej = 1'b0;
            end
            default: begin
                cmd_rej = 1'b1;
            end
        endcase

        cmd_addr = ADDR_W'(ADDR_W'(cmd_port) * ADDR_W'(NUM_PRIORITIES)) + ADDR_W'(cmd_pri);

        cmd_res.out_port      = r_item.port;
        cmd_res.out_level     = port_ok ? cmd_lvl : 1'b0;
        cmd_res.driving       = port_ok ? r_drive[cmd_port] : 1'b0;
        cmd_res.run_done      = 1'b0;
        cmd_res.done_priority = 2'd0;
        cmd_res.rejected      = !port_ok || cmd_rej;
        cmd_res.last          = 1'b1;
    end

    always_comb begin
        flags.in_valid   = i_item.valid;
        flags.is_cmd     = r_item.operation != OP_TICK;
        flags.ports_done = r_cnt >= n_ports;
        flags.out_busy   = r_out_valid && !o_result.ready;
    end

    pobc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    assign ram_we    = (ctl.upd_tick && r_any) || (ctl.exec_cmd && port_ok && cmd_we);
    assign ram_waddr = ctl.upd_tick ? r_slot_addr : cmd_addr;
    assign ram_wdata = ctl.upd_tick ? tick_nxt : cmd_slot;

    pobc_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ctl.rd_slot),
        .i_raddr (tick_addr),
        .o_rdata (cur)
    );

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item <= i_item.data;
        end
        if (ctl.rd_slot) begin
            r_any       <= sel_any;
            r_sel_pri   <= sel_pri;
            r_slot_addr <= tick_addr;
        end
        if (ctl.upd_tick) begin
            r_out <= tick_res;
        end else if (ctl.exec_cmd) begin
            r_out <= cmd_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ports_in_use <= PORTS_IN_USE_RST;
            r_cnt          <= '0;
            r_level        <= '0;
            r_drive        <= '0;
            r_out_valid    <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_act[p] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_ports_in_use <= i_cfg.data;
            end
            if (acc) begin
                r_cnt <= '0;
            end
            if (ctl.upd_tick) begin
                r_cnt            <= r_cnt + CNT_W'(1);
                r_drive[cnt_idx] <= r_any;
                if (r_any) begin
                    r_level[cnt_idx] <= tick_lvl;
                    if (tick_end) begin
                        r_act[cnt_idx][r_sel_pri] <= 1'b0;
                    end
                end
            end
            if (ctl.exec_cmd && port_ok) begin
                r_level[cmd_port] <= cmd_lvl;
                if (cmd_set) begin
                    r_act[cmd_port][cmd_pri] <= 1'b1;
                end else if (cmd_clr) begin
                    r_act[cmd_port][cmd_pri] <= 1'b0;
                end
            end
            if (ctl.upd_tick || ctl.exec_cmd) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_item.ready   = ctl.accept;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

`include "assert_macros.svh"

    `POBC_ASSERT_IMP(a_load_free, i_clk, i_rst_n, ctl.upd_tick || ctl.exec_cmd, !r_out_valid || o_result.ready)
    `POBC_ASSERT_IMP(a_done_drv, i_clk, i_rst_n, r_out_valid && r_out.run_done, r_out.driving)
    `POBC_ASSERT_IMP(a_rej_last, i_clk, i_rst_n, r_out_valid && r_out.rejected, r_out.last)
    `POBC_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)
endmodule

// File: tb/sv/tb.sv
module tb;
    import pobc_pkg::*;

    localparam int NPORT = NUM_PORTS_DEF;
    localparam int NPRI = NUM_PRIORITIES_DEF;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS = 32;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    pobc_item_if   item_bus ();
    pobc_result_if result_bus ();
    pobc_cfg_if    cfg_bus ();

    prioritized_output_blink_controller u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    logic [CFG_W-1:0] ports_cfg;
    logic             port_level_q [NPORT];
    logic             port_drv_q [NPORT];
    t_slot            slot_q [NPORT*NPRI];
    t_result          pending_reports [$];

    int errors = 0;
    int items_sent = 0;
    int reports_seen = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int hold_len = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int served_ports();
        return (int'(ports_cfg) > NPORT) ? NPORT : int'(ports_cfg);
    endfunction

    function automatic t_result make_report(input logic [2:0] port, input logic lvl,
                                            input logic drv, input logic done,
                                            input logic [1:0] pri, input logic rej,
                                            input logic last);
        t_result r;
        r.out_port = port;
        r.out_level = lvl;
        r.driving = drv;
        r.run_done = done;
        r.done_priority = pri;
        r.rejected = rej;
        r.last = last;
        return r;
    endfunction

    function automatic t_item blink_cmd(input logic [2:0] op, input logic [2:0] port,
                                        input logic [1:0] pri, input logic [15:0] cyc,
                                        input logic [7:0] hi, input logic [7:0] lo,
                                        input logic ntf, input logic lvl);
        t_item it;
        it.operation = op;
        it.port = port;
        it.priority_req = pri;
        it.cycles = cyc;
        it.high_ticks = hi;
        it.low_ticks = lo;
        it.notify = ntf;
        it.drive_level = lvl;
        return it;
    endfunction

    task automatic load_slot(input int s, input logic [15:0] cyc, input logic [7:0] hi,
                             input logic [7:0] lo, input logic ntf);
        slot_q[s].remaining = cyc;
        slot_q[s].high_count = hi;
        slot_q[s].low_count = lo;
        slot_q[s].high_reload = hi;
        slot_q[s].low_reload = lo;
        slot_q[s].notify_en = ntf;
    endtask

    // Only the first slot with cycles left, from priority 0 down, acts on a tick.
    task automatic service_port(input int p, output logic done, output logic [1:0] dpri);
        int s;
        logic found;
        done = 1'b0;
        dpri = '0;
        found = 1'b0;
        port_drv_q[p] = 1'b0;
        for (int j = 0; j < NPRI; j++) begin
            s = p * NPRI + j;
            if (!found && slot_q[s].remaining != 0) begin
                found = 1'b1;
                port_drv_q[p] = 1'b1;
                if (slot_q[s].high_count > 0) begin
                    slot_q[s].high_count--;
                    port_level_q[p] = 1'b1;
                end else begin
                    if (slot_q[s].low_count > 0) begin
                        slot_q[s].low_count--;
                        port_level_q[p] = 1'b0;
                    end
                    if (slot_q[s].low_count == 0) begin
                        if (slot_q[s].remaining != FOREVER_CYCLES) begin
                            slot_q[s].remaining--;
                        end
                        if (slot_q[s].remaining == 0 && slot_q[s].notify_en) begin
                            done = 1'b1;
                            dpri = 2'(j);
                        end
                        slot_q[s].high_count = slot_q[s].high_reload;
                        slot_q[s].low_count = slot_q[s].low_reload;
                    end
                end
            end
        end
    endtask

    task automatic advance_blink_state(input t_item it);
        int n;
        int base;
        logic rej;
        logic done;
        logic [1:0] dpri;
        n = served_ports();
        base = it.port * NPRI;
        rej = 1'b0;
        if (it.operation == OP_TICK) begin
            for (int p = 0; p < n; p++) begin
                service_port(p, done, dpri);
                pending_reports.push_back(make_report(3'(p), port_level_q[p], port_drv_q[p],
                                                      done, dpri, 1'b0, p == n - 1));
            end
        end else if (it.port >= n) begin
            pending_reports.push_back(make_report(it.port, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 1'b1));
        end else begin
            case (it.operation)
                OP_START: begin
                    if (it.cycles == 0 || (it.high_ticks == 0 && it.low_ticks == 0)) begin
                        rej = 1'b1;
                    end else begin
                        load_slot(base + it.priority_req, it.cycles, it.high_ticks,
                                  it.low_ticks, it.notify);
                    end
                end
                OP_STOP: begin
                    slot_q[base + it.priority_req].remaining = '0;
                    port_level_q[it.port] = 1'b0;
                end
                OP_INSTALL: begin
                    if (it.high_ticks == 0 && it.low_ticks == 0) begin
                        rej = 1'b1;
                    end else begin
                        load_slot(base + NPRI - 1, FOREVER_CYCLES, it.high_ticks,
                                  it.low_ticks, 1'b0);
                    end
                end
                OP_REMOVE: begin
                    slot_q[base + NPRI - 1].remaining = '0;
                    port_level_q[it.port] = 1'b0;
                end
                OP_SET_LEVEL: begin
                    port_level_q[it.port] = it.drive_level;
                end
                OP_QUERY: begin
                end
                default: begin
                    rej = 1'b1;
                end
            endcase
            pending_reports.push_back(make_report(it.port, port_level_q[it.port],
                                                  port_drv_q[it.port], 1'b0, 2'd0, rej, 1'b1));
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat that accepts the item.
    task automatic send_item(input t_item it);
        item_bus.valid = 1'b1;
        item_bus.data = it;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        advance_blink_state(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic sender_pause();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                item_bus.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_reports();
        item_bus.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ports_cfg(input logic [CFG_W-1:0] value);
        drain_reports();
        cfg_bus.valid = 1'b1;
        cfg_bus.data = value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        ports_cfg = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic t_item random_item();
        t_item it;
        int n;
        int sel;
        n = served_ports();
        sel = $urandom_range(0, 99);
        it.port = 3'($urandom_range(0, 7));
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            it.port = 3'($urandom_range(0, n - 1));
        end
        it.priority_req = 2'($urandom_range(0, 3));
        it.notify = 1'($urandom_range(0, 1));
        it.drive_level = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) begin
            it.cycles = 16'($urandom);
            it.high_ticks = 8'($urandom);
            it.low_ticks = 8'($urandom);
        end else begin
            it.cycles = ($urandom_range(0, 9) == 0) ? FOREVER_CYCLES : 16'($urandom_range(0, 4));
            it.high_ticks = 8'($urandom_range(0, 3));
            it.low_ticks = 8'($urandom_range(0, 3));
        end
        if (sel < 45) begin
            it.operation = OP_TICK;
        end else if (sel < 70) begin
            it.operation = OP_START;
        end else if (sel < 76) begin
            it.operation = OP_STOP;
        end else if (sel < 81) begin
            it.operation = OP_INSTALL;
        end else if (sel < 86) begin
            it.operation = OP_REMOVE;
        end else if (sel < 91) begin
            it.operation = OP_SET_LEVEL;
        end else if (sel < 97) begin
            it.operation = OP_QUERY;
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : check_blk
        t_result want;
        t_result got;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got = result_bus.data;
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("result beat with no expected report: %p", got);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("out_port", 8'(want.out_port), 8'(got.out_port));
                check_field("out_level", 8'(want.out_level), 8'(got.out_level));
                check_field("driving", 8'(want.driving), 8'(got.driving));
                check_field("run_done", 8'(want.run_done), 8'(got.run_done));
                check_field("done_priority", 8'(want.done_priority), 8'(got.done_priority));
                check_field("rejected", 8'(want.rejected), 8'(got.rejected));
                check_field("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    initial begin : rx_blk
        t_rx_mode mode;
        int mode_left;
        int phase;
        result_bus.ready = 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_len > 0) begin
                result_bus.ready = 1'b0;
                hold_len--;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: result_bus.ready = 1'b1;
                    RX_COIN: result_bus.ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: result_bus.ready = (phase % 5) != 0;
                    default: result_bus.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic test_after_reset();
        send_item(blink_cmd(OP_QUERY, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_QUERY, 3'd7, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    endtask

    task automatic test_directed_ops();
        send_item(blink_cmd(OP_START, 3'd0, 2'd0, 16'd1, 8'd1, 8'd1, 1'b1, 1'b0));
        repeat (3) send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_START, 3'd1, 2'd3, 16'd0, 8'd4, 8'd4, 1'b1, 1'b0));
        send_item(blink_cmd(OP_START, 3'd1, 2'd1, 16'd5, 8'd0, 8'd0, 1'b1, 1'b0));
        send_item(blink_cmd(OP_START, 3'd1, 2'd1, FOREVER_CYCLES, 8'd0, 8'd2, 1'b1, 1'b1));
        send_item(blink_cmd(OP_INSTALL, 3'd2, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_INSTALL, 3'd2, 2'd0, 16'd0, 8'hff, 8'hff, 1'b1, 1'b1));
        send_item(blink_cmd(OP_START, 3'd2, 2'd0, 16'd2, 8'd2, 8'd0, 1'b1, 1'b0));
        send_item(blink_cmd(OP_SET_LEVEL, 3'd3, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        send_item(blink_cmd(OP_SET_LEVEL, 3'd4, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        send_item(blink_cmd(OP_SET_LEVEL, 3'd3, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        repeat (4) send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_STOP, 3'd2, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_REMOVE, 3'd2, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_STOP, 3'd1, 2'd1, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_UNUSED, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_UNUSED, 3'd6, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_START, 3'd7, 2'd0, 16'd3, 8'd1, 8'd1, 1'b1, 1'b0));
        send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    endtask

    task automatic test_port_settings();
        write_ports_cfg(4'd0);
        send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_QUERY, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_START, 3'd0, 2'd0, 16'd2, 8'd1, 8'd1, 1'b1, 1'b0));
        write_ports_cfg(4'd15);
        send_item(blink_cmd(OP_START, 3'd7, 2'd2, 16'd2, 8'd1, 8'd1, 1'b1, 1'b0));
        repeat (4) send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        write_ports_cfg(4'd1);
        send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_QUERY, 3'd3, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(blink_cmd(OP_SET_LEVEL, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        write_ports_cfg(4'd8);
        send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_ports_cfg((ph == 0) ? 4'd8 : 4'($urandom_range(0, 15)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_item(random_item());
                sender_pause();
            end
        end
    endtask

    // A long result stall while ticks keep coming fills the block and stalls its input.
    task automatic test_result_backpressure();
        write_ports_cfg(4'd8);
        for (int p = 0; p < NPORT; p++) begin
            send_item(blink_cmd(OP_START, 3'(p), 2'(p % NPRI), 16'd3, 8'd1, 8'd2, 1'b1, 1'b0));
        end
        hold_len = 300;
        repeat (25) send_item(blink_cmd(OP_TICK, 3'd0, 2'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        drain_reports();
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.data = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        ports_cfg = PORTS_IN_USE_RST;
        for (int p = 0; p < NPORT; p++) begin
            port_level_q[p] = 1'b0;
            port_drv_q[p] = 1'b0;
        end
        for (int s = 0; s < NPORT * NPRI; s++) begin
            slot_q[s] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_after_reset();
        test_directed_ops();
        test_port_settings();
        test_random_traffic();
        test_result_backpressure();
        drain_reports();

        $display("Sent %0d items, checked %0d result beats, wrote the port count %0d times.",
                 items_sent, reports_seen, cfg_writes);
        $display("Covered every operation, port counts 0 to 15 and a long result stall.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/pobc_pkg.sv
src/pobc_item_if.sv
src/pobc_result_if.sv
src/pobc_cfg_if.sv
src/pobc_ram.sv
src/pobc_seq.sv
src/prioritized_output_blink_controller.sv
tb/sv/tb.sv
